@@ sv/pdwt_pkg.sv @@
// ----------------------------------------------------------------------------
// pdwt_pkg: shared types and constants for point dedup within tolerance
// Beat layouts for both channels, field widths and the sequencer states.
// ----------------------------------------------------------------------------
package pdwt_pkg;

    localparam int COORD_W = 32;
    localparam int TOL_W   = 20;
    localparam int SLOT_W  = 8;
    localparam int DCNT_W  = 9;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    typedef struct packed {
        logic                      start_set;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } t_in_beat;

    typedef struct packed {
        logic              kept;
        logic [SLOT_W-1:0] slot_index;
        logic              table_full;
        logic [DCNT_W-1:0] distinct_count;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_state;

endpackage

@@ sv/pdwt_ram.sv @@
// ----------------------------------------------------------------------------
// pdwt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pdwt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/point_dedup_within_tolerance.sv @@
// ----------------------------------------------------------------------------
// point_dedup_within_tolerance: weld 3D points that lie within a tolerance
// Keeps a table of distinct points since the last start of set, searches it
// in slot order for the first point closer than the tolerance on every axis,
// and appends the point when no such entry exists.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  --------  ---------  -----------------------------  ------------------------
//  in        input      i_in_valid / o_in_ready        i_in   (t_in_beat)
//  out       output     o_out_valid / i_out_ready      o_out  (t_out_beat)
//  cfg       input      i_cfg_we (no wait)             i_cfg_wdata (tolerance)
//
//  An input beat is accepted in the idle state; the search state then reads
//  the table entries in slot order through the single RAM read port, up to
//  the entry count, fewer on an early match, and the shared compare unit
//  checks each entry the cycle after its read. The result then passes from
//  the done state to the output register for the handoff.
//  Synchronous active-low reset empties the table and sets tolerance to 1;
//  the RAM needs no clearing since only slots below the entry count are read.
//  A stalled output holds the finished beat; a new beat is still accepted and
//  searched, and its result waits in the done state until the register frees.
//
module point_dedup_within_tolerance
    import pdwt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_beat            i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_beat           o_out,
    input  logic                i_cfg_we,
    input  logic [TOL_W-1:0]    i_cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = 3 * COORD_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    // Control and point registers
    t_state              r_state,   n_state;
    logic [TOL_W-1:0]    r_tol;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [CNT_W-1:0]    r_rd_idx,  n_rd_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic [ENT_W-1:0]    r_pt,      n_pt;
    t_out_beat           r_res,     n_res;
    logic                r_out_vld, n_out_vld;
    t_out_beat           r_out,     n_out;

    // RAM port signals
    logic                ram_we;
    logic                ram_re;
    logic [ENT_W-1:0]    ram_rdata;

    logic                hit;
    logic                last;

    // Per-axis closeness at 33 bits so the difference never wraps
    function automatic logic axis_close(
        input logic [COORD_W-1:0] stored,
        input logic [COORD_W-1:0] pos,
        input logic [TOL_W-1:0]   tol
    );
        logic signed [COORD_W:0] diff;
        logic signed [COORD_W:0] tol_s;
        diff  = signed'({stored[COORD_W-1], stored}) - signed'({pos[COORD_W-1], pos});
        tol_s = signed'((COORD_W + 1)'(tol));
        return (diff < tol_s) && (diff > -tol_s);
    endfunction

    pdwt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_pt),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Shared compare unit: the entry read last cycle against the held point
    assign hit = r_cmp_vld
        && axis_close(ram_rdata[3*COORD_W-1:2*COORD_W], r_pt[3*COORD_W-1:2*COORD_W], r_tol)
        && axis_close(ram_rdata[2*COORD_W-1:COORD_W],   r_pt[2*COORD_W-1:COORD_W],   r_tol)
        && axis_close(ram_rdata[COORD_W-1:0],           r_pt[COORD_W-1:0],           r_tol);

    // Last entry compared, or nothing to compare at all
    assign last = (r_count == '0)
        || (r_cmp_vld && ({1'b0, r_cmp_idx} == (IDX_W + 1)'(r_count - CNT_W'(1))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tol     <= TOL_RESET;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_idx  <= n_rd_idx;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
        end
        r_cmp_idx <= n_cmp_idx;
        r_pt      <= n_pt;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rd_idx   = r_rd_idx;
        n_cmp_vld  = 1'b0;
        n_cmp_idx  = r_rd_idx[IDX_W-1:0];
        n_pt       = r_pt;
        n_res      = r_res;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out      = r_out;
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    // Latch the point, empty the table on start of set
                    n_pt     = {i_in.pos_x, i_in.pos_y, i_in.pos_z};
                    n_rd_idx = '0;
                    if (i_in.start_set) begin
                        n_count = '0;
                    end
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    // First match ends the search
                    n_res.kept           = 1'b0;
                    n_res.slot_index     = SLOT_W'(r_cmp_idx);
                    n_res.table_full     = 1'b0;
                    n_res.distinct_count = DCNT_W'(r_count);
                    n_state              = ST_DONE;
                end else if (last) begin
                    if (r_count == CNT_FULL) begin
                        // Drop the point, table unchanged
                        n_res.kept           = 1'b0;
                        n_res.slot_index     = '0;
                        n_res.table_full     = 1'b1;
                        n_res.distinct_count = DCNT_W'(r_count);
                    end else begin
                        // Append at the next free slot
                        ram_we               = 1'b1;
                        n_count              = r_count + CNT_W'(1);
                        n_res.kept           = 1'b1;
                        n_res.slot_index     = SLOT_W'(r_count);
                        n_res.table_full     = 1'b0;
                        n_res.distinct_count = DCNT_W'(r_count + CNT_W'(1));
                    end
                    n_state = ST_DONE;
                end else if (r_rd_idx < r_count) begin
                    // Advance the read pointer, compare next cycle
                    ram_re    = 1'b1;
                    n_rd_idx  = r_rd_idx + CNT_W'(1);
                    n_cmp_vld = 1'b1;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // The entry count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count beyond table depth");

    // A compare in flight always refers to a written slot
    a_cmp_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> ({1'b0, r_cmp_idx} < (IDX_W + 1)'(r_count)))
        else $error("compare of an unwritten slot");

    // Every append grows the table by exactly one entry
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("append did not advance entry count");

    // A result never claims both kept and dropped
    a_kept_xor_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.kept && o_out.table_full))
        else $error("result both kept and table full");

endmodule
